[rtl/core/fdtd_pkg.sv]
package fdtd_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned SRC_W      = 11;
  localparam int unsigned NCELL_W    = 12;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned DIFF_W     = DATA_W + 1;
  localparam int unsigned PROD_W     = DIFF_W + COEF_W + 1;
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned COEF_SHIFT = 15;
  localparam int unsigned ROUND_HALF = 1 << (COEF_SHIFT - 1);
  localparam int unsigned MIN_CELLS  = 3;

  // APB register map
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_H_COEF   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_E_COEF   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SRC_CELL = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_NCELLS   = 2'd3;

  localparam logic [COEF_W-1:0]  H_COEF_RST   = 16'd16384;
  localparam logic [COEF_W-1:0]  E_COEF_RST   = 16'd16384;
  localparam logic [SRC_W-1:0]   SRC_CELL_RST = 11'd500;
  localparam logic [NCELL_W-1:0] NCELLS_RST   = 12'd2000;

  // item command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [COEF_W-1:0] h_coef;
    logic [COEF_W-1:0] e_coef;
    logic [SRC_W-1:0]  src_cell;
  } cfg_t;

  typedef struct packed {
    logic clear;    // write zero into both fields at addr
    logic issue;    // sweep read of both fields at addr
    logic rd_item;  // read item: read e at the item's index
    logic take;     // item accepted, capture its fields
    logic load;     // load the output word
  } dp_cmd_t;

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-DATA_W:0] top;
    logic signed [DATA_W-1:0] r;
    top = v[SUM_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      r = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [DIFF_W-1:0] diff_word(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
    return {a[DATA_W-1], a} - {b[DATA_W-1], b};
  endfunction

  // old + round_half_up(prod / 2^COEF_SHIFT), saturated
  function automatic logic signed [DATA_W-1:0] round_add(input logic signed [DATA_W-1:0] old,
                                                         input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] shr;
    logic signed [SUM_W-1:0]  sum;
    rnd = prod + $signed(PROD_W'(ROUND_HALF));
    shr = rnd >>> COEF_SHIFT;
    sum = SUM_W'(shr) + SUM_W'(old);
    return sat_word(sum);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    return sat_word(SUM_W'(a) + SUM_W'(b));
  endfunction

endpackage

[rtl/core/fdtd_1d_yee_grid_engine_unit.sv]
// One-dimensional Yee grid engine: electric and magnetic field arrays of CELLS
// words each (signed Q11.20, saturating), set up over an APB port at byte
// addresses 0x0 h coefficient, 0x4 e coefficient, 0x8 source cell, 0xC cells
// in use. A step word sweeps the grid through the two field memories at one
// cell per clock in a seven-stage pipeline, with the cells in use clamped to
// 3..CELLS; the next word is taken only after the result of the last one has
// been loaded into the output register. Each item returns one word, held in an
// output register while the next item is taken. After reset both memories are
// zeroed by a clearing pass over all CELLS cells, during which in_ready_o stays
// low; configuration writes are taken throughout.
module fdtd_1d_yee_grid_engine_unit #(
  parameter int unsigned CELLS = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fdtd_pkg::PADDR_W-1:0]        paddr,
  input  logic [fdtd_pkg::PDATA_W-1:0]        pwdata,
  output logic [fdtd_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  source_amplitude_i,
  input  logic [fdtd_pkg::IDX_W-1:0]          cell_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [fdtd_pkg::DATA_W-1:0]  ez_value_o,
  output logic                                step_done_o,
  output logic                                bad_index_o
);

  localparam int unsigned NW = $clog2(CELLS + 1);

  fdtd_pkg::cfg_t    cfg;
  fdtd_pkg::dp_cmd_t dp_cmd;
  logic [NW-1:0]     ncells;
  logic [NW-1:0]     addr;
  logic              busy;

  assign pready = 1'b1;

  fdtd_regs #(.CELLS(CELLS)) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .cfg_o    (cfg),
    .ncells_o (ncells)
  );

  fdtd_ctrl #(.CELLS(CELLS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ncells_i    (ncells),
    .busy_i      (busy),
    .dp_cmd_o    (dp_cmd),
    .addr_o      (addr)
  );

  fdtd_dp #(.CELLS(CELLS)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .dp_cmd_i           (dp_cmd),
    .addr_i             (addr),
    .ncells_i           (ncells),
    .cfg_i              (cfg),
    .source_amplitude_i (source_amplitude_i),
    .cell_index_i       (cell_index_i),
    .busy_o             (busy),
    .ez_value_o         (ez_value_o),
    .step_done_o        (step_done_o),
    .bad_index_o        (bad_index_o)
  );

endmodule

[rtl/core/fdtd_ram.sv]
module fdtd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/core/fdtd_regs.sv]
module fdtd_regs #(
  parameter int unsigned CELLS = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdtd_pkg::PADDR_W-1:0]      paddr,
  input  logic [fdtd_pkg::PDATA_W-1:0]      pwdata,
  output logic [fdtd_pkg::PDATA_W-1:0]      prdata,
  output fdtd_pkg::cfg_t                    cfg_o,
  output logic [$clog2(CELLS+1)-1:0]        ncells_o
);

  localparam int unsigned NW = $clog2(CELLS + 1);
  localparam int unsigned MW = (fdtd_pkg::NCELL_W > NW) ? fdtd_pkg::NCELL_W : NW;

  logic [fdtd_pkg::COEF_W-1:0]  h_coef_q;
  logic [fdtd_pkg::COEF_W-1:0]  e_coef_q;
  logic [fdtd_pkg::SRC_W-1:0]   src_q;
  logic [fdtd_pkg::NCELL_W-1:0] ncells_q;
  logic [fdtd_pkg::REG_IDX_W-1:0] reg_idx;
  logic [MW-1:0] ncells_x;

  assign reg_idx = paddr[fdtd_pkg::PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_coef_q <= fdtd_pkg::H_COEF_RST;
      e_coef_q <= fdtd_pkg::E_COEF_RST;
      src_q    <= fdtd_pkg::SRC_CELL_RST;
      ncells_q <= fdtd_pkg::NCELLS_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        fdtd_pkg::REG_H_COEF:   h_coef_q <= pwdata[fdtd_pkg::COEF_W-1:0];
        fdtd_pkg::REG_E_COEF:   e_coef_q <= pwdata[fdtd_pkg::COEF_W-1:0];
        fdtd_pkg::REG_SRC_CELL: src_q    <= pwdata[fdtd_pkg::SRC_W-1:0];
        fdtd_pkg::REG_NCELLS:   ncells_q <= pwdata[fdtd_pkg::NCELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fdtd_pkg::REG_H_COEF:   prdata = fdtd_pkg::PDATA_W'(h_coef_q);
      fdtd_pkg::REG_E_COEF:   prdata = fdtd_pkg::PDATA_W'(e_coef_q);
      fdtd_pkg::REG_SRC_CELL: prdata = fdtd_pkg::PDATA_W'(src_q);
      fdtd_pkg::REG_NCELLS:   prdata = fdtd_pkg::PDATA_W'(ncells_q);
      default:                prdata = '0;
    endcase
  end

  // active cell count, clamped to [3, CELLS]
  assign ncells_x = MW'(ncells_q);
  always_comb begin
    if (ncells_x < MW'(fdtd_pkg::MIN_CELLS)) begin
      ncells_o = NW'(fdtd_pkg::MIN_CELLS);
    end else if (ncells_x > MW'(CELLS)) begin
      ncells_o = NW'(CELLS);
    end else begin
      ncells_o = NW'(ncells_x);
    end
  end

  assign cfg_o.h_coef   = h_coef_q;
  assign cfg_o.e_coef   = e_coef_q;
  assign cfg_o.src_cell = src_q;

endmodule

[rtl/core/fdtd_dp.sv]
module fdtd_dp #(
  parameter int unsigned CELLS = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fdtd_pkg::dp_cmd_t                   dp_cmd_i,
  input  logic [$clog2(CELLS+1)-1:0]          addr_i,
  input  logic [$clog2(CELLS+1)-1:0]          ncells_i,
  input  fdtd_pkg::cfg_t                      cfg_i,
  input  logic signed [fdtd_pkg::DATA_W-1:0]  source_amplitude_i,
  input  logic [fdtd_pkg::IDX_W-1:0]          cell_index_i,
  output logic                                busy_o,
  output logic signed [fdtd_pkg::DATA_W-1:0]  ez_value_o,
  output logic                                step_done_o,
  output logic                                bad_index_o
);

  localparam int unsigned AW  = $clog2(CELLS);
  localparam int unsigned NW  = $clog2(CELLS + 1);
  localparam int unsigned IXW = (fdtd_pkg::IDX_W > NW) ? fdtd_pkg::IDX_W : NW;
  localparam int unsigned SW  = (fdtd_pkg::SRC_W > AW) ? fdtd_pkg::SRC_W : AW;
  localparam int unsigned DW  = fdtd_pkg::DATA_W;

  // field memories
  logic          e_we, h_we, e_re;
  logic [AW-1:0] e_waddr, h_waddr, e_raddr;
  logic [DW-1:0] e_wdata, h_wdata;
  logic signed [DW-1:0] e_rd, h_rd;

  // sweep pipeline, one cell per stage
  logic                           s1_vld_q;
  logic [NW-1:0]                  s1_r_q;
  logic signed [DW-1:0]           e_last_q, h_last_q;
  logic                           s2_vld_q;
  logic [AW-1:0]                  s2_j_q;
  logic signed [fdtd_pkg::DIFF_W-1:0] s2_diff_q;
  logic signed [DW-1:0]           s2_hold_q, s2_eold_q;
  logic                           s3_vld_q;
  logic [AW-1:0]                  s3_j_q;
  logic signed [fdtd_pkg::PROD_W-1:0] s3_prod_q;
  logic signed [DW-1:0]           s3_hold_q, s3_eold_q;
  logic                           s4_vld_q;
  logic [AW-1:0]                  s4_j_q;
  logic signed [DW-1:0]           s4_hnew_q, s4_eold_q, hprev_q;
  logic                           s5_vld_q;
  logic [AW-1:0]                  s5_j_q;
  logic signed [fdtd_pkg::DIFF_W-1:0] s5_diff_q;
  logic signed [DW-1:0]           s5_eold_q;
  logic                           s6_vld_q;
  logic [AW-1:0]                  s6_j_q;
  logic signed [fdtd_pkg::PROD_W-1:0] s6_prod_q;
  logic signed [DW-1:0]           s6_eold_q;
  logic                           s7_vld_q;
  logic [AW-1:0]                  s7_j_q;
  logic signed [DW-1:0]           s7_enew_q;

  logic [AW-1:0]        last_j;
  logic signed [DW-1:0] h_new, e_new, e_out;
  logic [IXW-1:0]       idx_x;

  // item capture and output word
  logic signed [DW-1:0] amp_q;
  logic                 step_q, bad_q;
  logic signed [DW-1:0] ez_q;
  logic                 step_done_q, bad_out_q;

  assign last_j = AW'(ncells_i - 1'b1);
  assign idx_x  = IXW'(cell_index_i);

  fdtd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_e_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rd)
  );

  fdtd_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_h_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .re_i    (dp_cmd_i.issue),
    .raddr_i (addr_i[AW-1:0]),
    .rdata_o (h_rd)
  );

  assign e_re    = dp_cmd_i.issue || dp_cmd_i.rd_item;
  assign e_raddr = dp_cmd_i.rd_item ? idx_x[AW-1:0] : addr_i[AW-1:0];

  assign h_new = fdtd_pkg::round_add(s3_hold_q, s3_prod_q);
  assign e_new = fdtd_pkg::round_add(s6_eold_q, s6_prod_q);
  // source lands after the conductor cells are zeroed
  assign e_out = (SW'(s7_j_q) == SW'(cfg_i.src_cell)) ?
                 fdtd_pkg::sat_add(s7_enew_q, amp_q) : s7_enew_q;

  always_comb begin
    if (dp_cmd_i.clear) begin
      e_we    = 1'b1;
      e_waddr = addr_i[AW-1:0];
      e_wdata = '0;
      h_we    = 1'b1;
      h_waddr = addr_i[AW-1:0];
      h_wdata = '0;
    end else begin
      e_we    = s7_vld_q;
      e_waddr = s7_j_q;
      e_wdata = e_out;
      h_we    = s3_vld_q && (s3_j_q != last_j);
      h_waddr = s3_j_q;
      h_wdata = h_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= dp_cmd_i.issue;
      // read r yields the magnetic update of cell r-1
      s2_vld_q <= s1_vld_q && (s1_r_q != '0);
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q <= addr_i;
    if (s1_vld_q) begin
      e_last_q <= e_rd;
      h_last_q <= h_rd;
    end
    s2_j_q    <= AW'(s1_r_q - 1'b1);
    s2_diff_q <= fdtd_pkg::diff_word(e_rd, e_last_q);
    s2_hold_q <= h_last_q;
    s2_eold_q <= e_last_q;

    s3_j_q    <= s2_j_q;
    s3_prod_q <= s2_diff_q * $signed({1'b0, cfg_i.h_coef});
    s3_hold_q <= s2_hold_q;
    s3_eold_q <= s2_eold_q;

    s4_j_q    <= s3_j_q;
    s4_hnew_q <= h_new;
    s4_eold_q <= s3_eold_q;

    if (s4_vld_q) begin
      hprev_q <= s4_hnew_q;
    end
    s5_j_q    <= s4_j_q;
    s5_diff_q <= fdtd_pkg::diff_word(s4_hnew_q, hprev_q);
    s5_eold_q <= s4_eold_q;

    s6_j_q    <= s5_j_q;
    s6_prod_q <= s5_diff_q * $signed({1'b0, cfg_i.e_coef});
    s6_eold_q <= s5_eold_q;

    s7_j_q <= s6_j_q;
    if ((s6_j_q == '0) || (s6_j_q == last_j)) begin
      s7_enew_q <= '0;
    end else begin
      s7_enew_q <= e_new;
    end

    if (dp_cmd_i.take) begin
      amp_q  <= source_amplitude_i;
      step_q <= !dp_cmd_i.rd_item;
      bad_q  <= dp_cmd_i.rd_item && (idx_x >= IXW'(ncells_i));
    end

    if (dp_cmd_i.load) begin
      ez_q        <= (step_q || bad_q) ? '0 : e_rd;
      step_done_q <= step_q;
      bad_out_q   <= bad_q;
    end
  end

  assign busy_o = s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q ||
                  s5_vld_q || s6_vld_q || s7_vld_q;

  assign ez_value_o  = ez_q;
  assign step_done_o = step_done_q;
  assign bad_index_o = bad_out_q;

endmodule

[rtl/core/fdtd_ctrl.sv]
module fdtd_ctrl #(
  parameter int unsigned CELLS = 2048
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  logic [$clog2(CELLS+1)-1:0]  ncells_i,
  input  logic                        busy_i,
  output fdtd_pkg::dp_cmd_t           dp_cmd_o,
  output logic [$clog2(CELLS+1)-1:0]  addr_o
);

  localparam int unsigned NW = $clog2(CELLS + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          out_vld_q, out_vld_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    dp_cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        dp_cmd_o.clear = 1'b1;
        if (cnt_q == NW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dp_cmd_o.take = 1'b1;
          cnt_d         = '0;
          if (in_cmd_i == fdtd_pkg::CMD_READ) begin
            dp_cmd_o.rd_item = 1'b1;
            state_d          = ST_DONE;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        // reads 0..n; the extra slot carries the far conductor cell
        dp_cmd_o.issue = 1'b1;
        if (cnt_q == ncells_i) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          dp_cmd_o.load = 1'b1;
          out_vld_d     = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign addr_o      = cnt_q;
  assign out_valid_o = out_vld_q;

endmodule

[tb/fdtd_1d_yee_grid_engine_unit_tb.sv]
module fdtd_1d_yee_grid_engine_unit_tb;

  localparam int unsigned GRID_CELLS = 2048;

  typedef struct packed {
    logic signed [fdtd_pkg::DATA_W-1:0] ez;
    logic                               step_done;
    logic                               bad_index;
  } grid_result_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [fdtd_pkg::PADDR_W-1:0]        paddr;
  logic [fdtd_pkg::PDATA_W-1:0]        pwdata;
  logic [fdtd_pkg::PDATA_W-1:0]        prdata;
  logic                                pready;
  logic                                in_valid_i;
  logic                                in_ready_o;
  logic                                cmd_i;
  logic signed [fdtd_pkg::DATA_W-1:0]  source_amplitude_i;
  logic [fdtd_pkg::IDX_W-1:0]          cell_index_i;
  logic                                out_valid_o;
  logic                                out_ready_i;
  logic signed [fdtd_pkg::DATA_W-1:0]  ez_value_o;
  logic                                step_done_o;
  logic                                bad_index_o;

  // grid copy and register copy for the predictor
  logic signed [fdtd_pkg::DATA_W-1:0] e_grid [GRID_CELLS];
  logic signed [fdtd_pkg::DATA_W-1:0] h_grid [GRID_CELLS];
  logic [fdtd_pkg::COEF_W-1:0]        h_coef_cfg;
  logic [fdtd_pkg::COEF_W-1:0]        e_coef_cfg;
  logic [fdtd_pkg::SRC_W-1:0]         src_cfg;
  logic [fdtd_pkg::NCELL_W-1:0]       ncells_cfg;

  grid_result_t pending_results[$];

  int error_count;
  int steps_sent;
  int reads_sent;
  int bad_reads_sent;
  int reg_writes;
  int source_gap_pct;
  int sink_stall_pct;

  fdtd_1d_yee_grid_engine_unit #(
    .CELLS(GRID_CELLS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cmd_i             (cmd_i),
    .source_amplitude_i(source_amplitude_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .ez_value_o        (ez_value_o),
    .step_done_o       (step_done_o),
    .bad_index_o       (bad_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #8000000;
    $display("timeout at %0t, %0d words still outstanding", $time, pending_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic signed [fdtd_pkg::DATA_W-1:0] clip_word(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[fdtd_pkg::DATA_W-1:0];
  endfunction

  // old + round half up(coef * (hi - lo) / 2^15), saturated
  function automatic logic signed [fdtd_pkg::DATA_W-1:0] courant_update(
    input logic signed [fdtd_pkg::DATA_W-1:0] old,
    input logic [fdtd_pkg::COEF_W-1:0]        coef,
    input logic signed [fdtd_pkg::DATA_W-1:0] hi,
    input logic signed [fdtd_pkg::DATA_W-1:0] lo
  );
    longint a;
    longint b;
    longint c;
    longint o;
    longint term;
    a = longint'(hi);
    b = longint'(lo);
    c = longint'(coef);
    o = longint'(old);
    term = ((a - b) * c + 64'sd16384) >>> 15;
    return clip_word(o + term);
  endfunction

  function automatic int unsigned grid_span(input logic [fdtd_pkg::NCELL_W-1:0] raw);
    int unsigned n;
    n = 32'(raw);
    if (n < fdtd_pkg::MIN_CELLS) n = fdtd_pkg::MIN_CELLS;
    if (n > GRID_CELLS) n = GRID_CELLS;
    return n;
  endfunction

  task automatic advance_grid(input logic signed [fdtd_pkg::DATA_W-1:0] amp);
    int unsigned n;
    int unsigned i;
    longint s;
    longint a;
    n = grid_span(ncells_cfg);
    for (i = 0; i + 1 < n; i++) begin
      h_grid[i] = courant_update(h_grid[i], h_coef_cfg, e_grid[i+1], e_grid[i]);
    end
    for (i = 1; i + 1 < n; i++) begin
      e_grid[i] = courant_update(e_grid[i], e_coef_cfg, h_grid[i], h_grid[i-1]);
    end
    e_grid[0] = '0;
    e_grid[n-1] = '0;
    // source goes in after the conductors are zeroed
    if (src_cfg < n) begin
      s = longint'(e_grid[src_cfg]);
      a = longint'(amp);
      e_grid[src_cfg] = clip_word(s + a);
    end
  endtask

  // ---------------- stimulus helpers ----------------

  task automatic send_word(
    input logic                               cmd,
    input logic signed [fdtd_pkg::DATA_W-1:0] amp,
    input logic [fdtd_pkg::IDX_W-1:0]         idx
  );
    grid_result_t r;
    while (source_gap_pct != 0 && $urandom_range(99) < source_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= cmd;
    source_amplitude_i <= amp;
    cell_index_i       <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    r = '0;
    if (cmd == fdtd_pkg::CMD_STEP) begin
      advance_grid(amp);
      r.step_done = 1'b1;
      steps_sent++;
    end else begin
      reads_sent++;
      if (idx < grid_span(ncells_cfg)) begin
        r.ez = e_grid[idx];
      end else begin
        r.bad_index = 1'b1;
        bad_reads_sent++;
      end
    end
    pending_results.push_back(r);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(input logic [fdtd_pkg::REG_IDX_W-1:0] which,
                             input logic [fdtd_pkg::PDATA_W-1:0]   value);
    logic [fdtd_pkg::PDATA_W-1:0] mask;
    logic [fdtd_pkg::PDATA_W-1:0] got;
    case (which)
      fdtd_pkg::REG_H_COEF, fdtd_pkg::REG_E_COEF:
        mask = fdtd_pkg::PDATA_W'((1 << fdtd_pkg::COEF_W) - 1);
      fdtd_pkg::REG_SRC_CELL:
        mask = fdtd_pkg::PDATA_W'((1 << fdtd_pkg::SRC_W) - 1);
      default:
        mask = fdtd_pkg::PDATA_W'((1 << fdtd_pkg::NCELL_W) - 1);
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value & mask;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      fdtd_pkg::REG_H_COEF:   h_coef_cfg = value[fdtd_pkg::COEF_W-1:0];
      fdtd_pkg::REG_E_COEF:   e_coef_cfg = value[fdtd_pkg::COEF_W-1:0];
      fdtd_pkg::REG_SRC_CELL: src_cfg    = value[fdtd_pkg::SRC_W-1:0];
      default:                ncells_cfg = value[fdtd_pkg::NCELL_W-1:0];
    endcase
    reg_writes++;
    // read it back
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if ((got & mask) !== (value & mask)) begin
      $display("%0t register %0d readback mismatch: expected %h, got %h",
               $time, which, value & mask, got);
      error_count++;
    end
  endtask

  task automatic set_grid(input int h, input int e, input int src, input int n);
    program_reg(fdtd_pkg::REG_H_COEF, h);
    program_reg(fdtd_pkg::REG_E_COEF, e);
    program_reg(fdtd_pkg::REG_SRC_CELL, src);
    program_reg(fdtd_pkg::REG_NCELLS, n);
  endtask

  function automatic logic signed [fdtd_pkg::DATA_W-1:0] pick_amplitude();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      return int'($urandom_range(0, 32'h40_0000)) - 32'sh20_0000;
    end else if (r < 85) begin
      return $urandom;
    end
    case ($urandom_range(3))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sh0;
      default: return -32'sd1;
    endcase
  endfunction

  // ---------------- result checker ----------------

  always @(posedge clk_i) begin : result_check
    grid_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: ez %0d step_done %b bad_index %b",
                 $time, ez_value_o, step_done_o, bad_index_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (ez_value_o !== want.ez) begin
          $display("%0t ez_value mismatch: expected %0d, got %0d",
                   $time, $signed(want.ez), ez_value_o);
          error_count++;
        end
        if (step_done_o !== want.step_done) begin
          $display("%0t step_done mismatch: expected %b, got %b",
                   $time, want.step_done, step_done_o);
          error_count++;
        end
        if (bad_index_o !== want.bad_index) begin
          $display("%0t bad_index mismatch: expected %b, got %b",
                   $time, want.bad_index, bad_index_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------- tests ----------------

  // fields cleared, reset register values in effect
  task automatic check_defaults_after_clear();
    send_word(fdtd_pkg::CMD_READ, $urandom, 11'd0);
    send_word(fdtd_pkg::CMD_READ, $urandom, 11'd2047);
    send_word(fdtd_pkg::CMD_STEP, 32'sh7fffffff, fdtd_pkg::IDX_W'($urandom));
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd500);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd1999);
    wait_for_results();
  endtask

  task automatic check_register_port();
    set_grid(0, 65535, 0, 0);
    set_grid(65535, 0, 2047, 4095);
  endtask

  task automatic check_directed_grid();
    // clamped to 3 cells, source on the left conductor, maximal coefficients
    set_grid(65535, 65535, 0, 0);
    send_word(fdtd_pkg::CMD_STEP, 32'sh80000000, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh7fffffff, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd1);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd2);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd3);
    send_word(fdtd_pkg::CMD_STEP, -32'sd1, 11'd2047);
    wait_for_results();
    // source on the right conductor
    set_grid(16384, 16384, 2, 2);
    send_word(fdtd_pkg::CMD_STEP, 32'sh7fffffff, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd2);
    wait_for_results();
    // source beyond the grid
    set_grid(16384, 16384, 5, 1);
    send_word(fdtd_pkg::CMD_STEP, 32'sd12345, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd5);
    wait_for_results();
    // clamped to the full grid, source on the last cell
    set_grid(32768, 32768, 2047, 4095);
    send_word(fdtd_pkg::CMD_STEP, 32'sh7fffffff, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd2047);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd2046);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd1024);
    wait_for_results();
    // unstable coefficients drive the grid into saturation
    set_grid(65535, 65535, 8, 16);
    send_word(fdtd_pkg::CMD_STEP, 32'sh7fffffff, 11'd0);
    send_word(fdtd_pkg::CMD_STEP, 32'sh7fffffff, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd7);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd8);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd9);
    send_word(fdtd_pkg::CMD_STEP, 32'sh80000000, 11'd0);
    send_word(fdtd_pkg::CMD_READ, 32'sh0, 11'd8);
    wait_for_results();
  endtask

  function automatic int pick_coef();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 32768);
    if (r < 80) return $urandom_range(32769, 65535);
    if (r < 90) return 0;
    return 65535;
  endfunction

  task automatic check_random_traffic(input int gap_pct, input int stall_pct, input int quota);
    int count;
    int n_raw;
    int n_eff;
    int src;
    int burst;
    int r;
    logic [fdtd_pkg::IDX_W-1:0] idx;
    source_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    count = 0;
    while (count < quota) begin
      // grid is idle here: every word returned
      wait_for_results();
      r = $urandom_range(99);
      if (r < 70)      n_raw = $urandom_range(3, 48);
      else if (r < 80) n_raw = $urandom_range(0, 2);
      else if (r < 90) n_raw = $urandom_range(49, 400);
      else             n_raw = $urandom_range(1900, 4095);
      n_eff = grid_span(fdtd_pkg::NCELL_W'(n_raw));
      r = $urandom_range(99);
      if (r < 75)      src = $urandom_range(0, n_eff - 1);
      else if (r < 80) src = 0;
      else if (r < 85) src = n_eff - 1;
      else             src = $urandom_range(0, 2047);
      set_grid(pick_coef(), pick_coef(), src, n_raw);
      burst = (n_eff > 400) ? 3 : $urandom_range(12, 24);
      repeat (burst) begin
        if ($urandom_range(99) < 55) begin
          send_word(fdtd_pkg::CMD_STEP, pick_amplitude(), fdtd_pkg::IDX_W'($urandom));
        end else begin
          if ($urandom_range(99) < 80) idx = fdtd_pkg::IDX_W'($urandom_range(0, n_eff - 1));
          else                         idx = fdtd_pkg::IDX_W'($urandom);
          send_word(fdtd_pkg::CMD_READ, $urandom, idx);
        end
        count++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid_i         = 1'b0;
    cmd_i              = fdtd_pkg::CMD_STEP;
    source_amplitude_i = '0;
    cell_index_i       = '0;
    source_gap_pct     = 0;
    sink_stall_pct     = 0;
    error_count        = 0;
    steps_sent         = 0;
    reads_sent         = 0;
    bad_reads_sent     = 0;
    reg_writes         = 0;
    h_coef_cfg         = fdtd_pkg::H_COEF_RST;
    e_coef_cfg         = fdtd_pkg::E_COEF_RST;
    src_cfg            = fdtd_pkg::SRC_CELL_RST;
    ncells_cfg         = fdtd_pkg::NCELLS_RST;
    for (int i = 0; i < GRID_CELLS; i++) begin
      e_grid[i] = '0;
      h_grid[i] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_defaults_after_clear();
    check_register_port();
    check_directed_grid();
    check_random_traffic(35, 55, 88);
    check_random_traffic(55, 35, 88);
    check_random_traffic(0, 0, 88);

    wait_for_results();
    repeat (GRID_CELLS + 16) @(posedge clk_i);

    $display("run covered %0d time steps, %0d cell reads (%0d out of grid), %0d register writes",
             steps_sent, reads_sent, bad_reads_sent, reg_writes);
    $display("clamped and full grids, conductor and off-grid sources, saturation, three stall mixes");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
